@@ rtl/core/fptw_pkg.sv @@
package fptw_pkg;

  localparam int PhysBits = 52;
  localparam int VaBits   = 48;
  localparam int AddrBits = 52;
  localparam int LeftBits = 22;

  // Physical address bits kept from an entry or root
  localparam logic [AddrBits-1:0] AddrMask =
    AddrBits'((64'd1 << PhysBits) - 64'd1);

  localparam logic FuncRequest = 1'b0;
  localparam logic FuncEntry   = 1'b1;

  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  localparam int PresentBit  = 0;
  localparam int PageSizeBit = 7;

  localparam logic [LeftBits-1:0] Page4kBytes = LeftBits'(24'h001000);
  localparam logic [LeftBits-1:0] Page2mBytes = LeftBits'(24'h200000);

  typedef enum logic [1:0] {
    LvlPml4 = 2'd0,
    LvlPdpt = 2'd1,
    LvlPd   = 2'd2,
    LvlPt   = 2'd3
  } level_t;

  typedef struct packed {
    logic              active;
    level_t            level;
    logic [VaBits-1:0] va;
  } walk_state_t;

  typedef struct packed {
    logic                kind;
    logic [AddrBits-1:0] read_addr;
    logic [AddrBits-1:0] phys_addr;
    logic [LeftBits-1:0] bytes_left;
    logic                fault;
    level_t              fault_level;
  } result_t;

  // 9-bit table index of the virtual address at a level
  function automatic logic [8:0] level_index(input logic [VaBits-1:0] va,
                                             input level_t lvl);
    logic [8:0] idx;
    unique case (lvl)
      LvlPml4: idx = va[47:39];
      LvlPdpt: idx = va[38:30];
      LvlPd:   idx = va[29:21];
      LvlPt:   idx = va[20:12];
      default: idx = 9'd0;
    endcase
    return idx;
  endfunction

  // Table frame plus index times eight
  function automatic logic [AddrBits-1:0] entry_addr(input logic [AddrBits-1:0] base,
                                                     input logic [VaBits-1:0] va,
                                                     input level_t lvl);
    logic [AddrBits-1:0] frame;
    frame = {base[AddrBits-1:12] & AddrMask[AddrBits-1:12], 12'd0};
    return {frame[AddrBits-1:12], level_index(va, lvl), 3'd0};
  endfunction

endpackage

@@ rtl/core/fptw_step.sv @@
module fptw_step (
  input  fptw_pkg::walk_state_t         state,
  input  logic                          func,
  input  logic [fptw_pkg::VaBits-1:0]   virt_addr,
  input  logic [fptw_pkg::AddrBits-1:0] table_root,
  input  logic [63:0]                   entry_data,
  output fptw_pkg::walk_state_t         state_next,
  output logic                          emit,
  output fptw_pkg::result_t             result
);

  fptw_pkg::level_t              lvl_up;
  logic [fptw_pkg::AddrBits-1:0] pte_addr;

  assign lvl_up   = fptw_pkg::level_t'(state.level + 2'd1);
  assign pte_addr = entry_data[fptw_pkg::AddrBits-1:0];

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '0;
    if (func == fptw_pkg::FuncRequest) begin
      if (!state.active) begin
        state_next.active = 1'b1;
        state_next.level  = fptw_pkg::LvlPml4;
        state_next.va     = virt_addr;
        emit              = 1'b1;
        result.kind       = fptw_pkg::KindRead;
        result.read_addr  = fptw_pkg::entry_addr(table_root, virt_addr, fptw_pkg::LvlPml4);
      end
    end else if (state.active) begin
      emit = 1'b1;
      priority if (!entry_data[fptw_pkg::PresentBit]) begin
        state_next.active  = 1'b0;
        state_next.level   = fptw_pkg::LvlPml4;
        result.kind        = fptw_pkg::KindDone;
        result.fault       = 1'b1;
        result.fault_level = state.level;
      end else if (state.level == fptw_pkg::LvlPd && entry_data[fptw_pkg::PageSizeBit]) begin
        state_next.active = 1'b0;
        state_next.level  = fptw_pkg::LvlPml4;
        result.kind       = fptw_pkg::KindDone;
        result.phys_addr  = {pte_addr[fptw_pkg::AddrBits-1:21]
                             & fptw_pkg::AddrMask[fptw_pkg::AddrBits-1:21],
                             state.va[20:0]};
        result.bytes_left = fptw_pkg::Page2mBytes - {1'b0, state.va[20:0]};
      end else if (state.level == fptw_pkg::LvlPt) begin
        state_next.active = 1'b0;
        state_next.level  = fptw_pkg::LvlPml4;
        result.kind       = fptw_pkg::KindDone;
        result.phys_addr  = {pte_addr[fptw_pkg::AddrBits-1:12]
                             & fptw_pkg::AddrMask[fptw_pkg::AddrBits-1:12],
                             state.va[11:0]};
        result.bytes_left = fptw_pkg::Page4kBytes - {10'd0, state.va[11:0]};
      end else begin
        // descend one level
        state_next.level = lvl_up;
        result.kind      = fptw_pkg::KindRead;
        result.read_addr = fptw_pkg::entry_addr(pte_addr, state.va, lvl_up);
      end
    end
  end

endmodule

@@ rtl/core/four_level_page_table_walker.sv @@
// A result beat leaves the output register in the cycle after its item is taken.
// Throughput: one item per cycle while the output register is free; the single output
// register sets the pace, and it refills in the same cycle its beat is taken.
// Reset (synchronous, rst high): walk goes idle at level PML4, held address and
// output valid clear.
module four_level_page_table_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          func,
  input  logic [fptw_pkg::VaBits-1:0]   virt_addr,
  input  logic [fptw_pkg::AddrBits-1:0] table_root,
  input  logic [63:0]                   entry_data,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          kind,
  output logic [fptw_pkg::AddrBits-1:0] read_addr,
  output logic [fptw_pkg::AddrBits-1:0] phys_addr,
  output logic [fptw_pkg::LeftBits-1:0] bytes_left,
  output logic                          fault,
  output logic [1:0]                    fault_level
);

  fptw_pkg::walk_state_t walk;
  fptw_pkg::walk_state_t walk_next;
  fptw_pkg::result_t     step_result;
  fptw_pkg::result_t     result;
  logic                  step_emit;
  logic                  item_take;

  assign item_ready = !result_valid || result_ready;
  assign item_take  = item_valid && item_ready;

  fptw_step u_step (
    .state      (walk),
    .func       (func),
    .virt_addr  (virt_addr),
    .table_root (table_root),
    .entry_data (entry_data),
    .state_next (walk_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (item_take) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_take) begin
      result_valid <= step_emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // hold payload until a new beat replaces it
  always_ff @(posedge clk) begin
    if (item_take && step_emit) begin
      result <= step_result;
    end
  end

  assign kind        = result.kind;
  assign read_addr   = result.read_addr;
  assign phys_addr   = result.phys_addr;
  assign bytes_left  = result.bytes_left;
  assign fault       = result.fault;
  assign fault_level = result.fault_level;

  a_fault_ends_walk: assert property (@(posedge clk) disable iff (rst)
    result_valid && fault |-> kind == fptw_pkg::KindDone && !walk.active)
    else $error("fault beat while walk still active");

  a_read_keeps_walk: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == fptw_pkg::KindRead |-> walk.active)
    else $error("entry read beat without an active walk");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == fptw_pkg::KindDone |-> !walk.active)
    else $error("finished beat while walk still active");

  a_bytes_left: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == fptw_pkg::KindDone && !fault
    |-> bytes_left != '0 && bytes_left <= fptw_pkg::Page2mBytes)
    else $error("bytes left out of range on finished walk");

endmodule
